// File: sv/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and codes for the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  localparam int unsigned DataW = 32;

endpackage

// File: sv/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue of signed words kept in a circular buffer RAM.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+------------------------------------------------
//  in      | input     | in_valid, in_ready, in_cmd, in_value
//  out     | output    | out_valid, out_ready, out_status, out_read_value,
//          |           | out_count
//
// pushes, clear, rejected commands and unused codes go straight to the output
// register; a pop or peek on a non-empty deque reads the RAM first (S_READ).
// the result sits in an output register, so a new command is taken in the
// cycle the previous result transfers. reset (synchronous, active low) empties
// the deque at once; RAM contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_cmd,
  input  logic signed [DataW-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic signed [DataW-1:0] out_read_value,
  output logic [CW-1:0]           out_count
);

  localparam logic [IW-1:0] IdxLast = IW'(DEPTH - 1);
  localparam logic [CW-1:0] OccFull = CW'(DEPTH);

  state_t            state_r, state_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DataW-1:0]  out_value_r, out_value_nxt;
  logic [CW-1:0]     out_count_r, out_count_nxt;

  logic              ram_wr_en;
  logic [IW-1:0]     ram_wr_addr;
  logic              ram_rd_en;
  logic [IW-1:0]     ram_rd_addr;
  logic [DataW-1:0]  ram_rd_data;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [IW-1:0]     head_prev;
  logic [IW-1:0]     head_next;
  logic [IW-1:0]     tail_prev;
  logic [IW-1:0]     tail_next;
  cmd_t              cmd;

  rbd_ram #(
    .WIDTH (DataW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cmd       = cmd_t'(in_cmd);
  assign is_full   = (occ_r == OccFull);
  assign is_empty  = (occ_r == '0);
  assign head_prev = (head_r == '0) ? IdxLast : head_r - 1'b1;
  assign head_next = (head_r == IdxLast) ? '0 : head_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? IdxLast : tail_r - 1'b1;
  assign tail_next = (tail_r == IdxLast) ? '0 : tail_r + 1'b1;

  // new command only while idle and the output slot is free or draining
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = '0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_DONE;
          out_value_nxt  = '0;
          out_valid_nxt  = 1'b1;
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_wr_en = 1'b1;
                if (is_empty) begin
                  head_nxt    = '0;
                  tail_nxt    = '0;
                  ram_wr_addr = '0;
                end else if (cmd == CMD_PUSH_FRONT) begin
                  head_nxt    = head_prev;
                  ram_wr_addr = head_prev;
                end else begin
                  tail_nxt    = tail_next;
                  ram_wr_addr = tail_next;
                end
                occ_nxt = occ_r + 1'b1;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = (cmd inside {CMD_POP_FRONT, CMD_PEEK_FRONT}) ? head_r : tail_r;
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                if (cmd inside {CMD_POP_FRONT, CMD_POP_BACK}) begin
                  occ_nxt = occ_r - 1'b1;
                  // last element out: indices stay until the next push or clear
                  if (occ_r != CW'(1)) begin
                    if (cmd == CMD_POP_FRONT) begin
                      head_nxt = head_next;
                    end else begin
                      tail_nxt = tail_prev;
                    end
                  end
                end
              end
            end
            CMD_CLEAR: begin
              occ_nxt  = '0;
              head_nxt = '0;
              tail_nxt = '0;
            end
            default: begin
            end
          endcase
          out_count_nxt = occ_nxt;
        end
      end
      S_READ: begin
        // read data is back; output slot was freed when the command came in
        out_value_nxt = ram_rd_data;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;
  assign out_count      = out_count_r;

endmodule
